[rtl/core/lru_tile_slot_list_assert.svh]
// assertion macros for the tile slot recency list
`ifndef LRU_TILE_SLOT_LIST_ASSERT_SVH
`define LRU_TILE_SLOT_LIST_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LTS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lts assertion failed");
// next-cycle implication
`define LTS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lts assertion failed");
`else
`define LTS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LTS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/lts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

    // field widths fixed by the interface
    localparam int OUT_W = 8;
    localparam int TPA_W = 9;
    localparam logic [TPA_W-1:0] TPA_RESET = 9'd16;

    // operation codes
    localparam logic [1:0] OP_APPEND_TAIL = 2'd0;
    localparam logic [1:0] OP_APPEND_HEAD = 2'd1;
    localparam logic [1:0] OP_UNLINK      = 2'd2;
    localparam logic [1:0] OP_RSVD        = 2'd3;

    // sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_S,
        ST_CHK,
        ST_RD_1,
        ST_WR_1,
        ST_RD_2,
        ST_WR_2,
        ST_WR_S,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/core/lru_tile_slot_list.sv]
`timescale 1ns / 1ps
`default_nettype none
// One item at a time: each request reads the entry of the named slot, then for a full unlink
// reads and rewrites both neighbors and writes the slot entry; an ignored or no-op request skips
// these link steps. The serial divider then runs and the result is loaded; the next item is taken
// after that, and a stalled result side holds the block in the done step.
// After reset a clearing pass rebuilds the list in index order;
// no item is accepted during it, configuration writes are taken at any time.
`include "lru_tile_slot_list_assert.svh"

module lru_tile_slot_list #(
    parameter int SLOT_COUNT = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [1:0]                    op,
    input  wire logic [7:0]                    slot_index,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic      [lts_pkg::OUT_W-1:0]     head_slot,
    output logic      [lts_pkg::OUT_W-1:0]     tail_slot,
    output logic                               list_empty,
    output logic      [lts_pkg::OUT_W-1:0]     head_tile_x,
    output logic      [lts_pkg::OUT_W-1:0]     head_tile_y,
    output logic                               rejected,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lts_pkg::TPA_W-1:0]     cfg_wr_data
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam int EW = 2 * LW + 1;
    localparam int IN_BIT = 2 * LW;
    localparam int OW = lts_pkg::OUT_W;
    localparam int TW = lts_pkg::TPA_W;
    localparam logic [LW-1:0] LINK_NONE = LW'(SLOT_COUNT);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    lts_pkg::state_t state_reg, state_next;

    logic [1:0]    op_reg, op_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          bad_reg, bad_next;
    logic          rej_reg, rej_next;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] tail_reg, tail_next;
    logic [SW-1:0] init_cnt_reg, init_cnt_next;
    logic [TW-1:0] tpa_reg, tpa_next;

    // planned neighbor updates and the new entry of the named slot
    logic          n1_en_reg, n1_en_next;
    logic [SW-1:0] n1_addr_reg, n1_addr_next;
    logic          n1_is_next_reg, n1_is_next_next;
    logic [LW-1:0] n1_val_reg, n1_val_next;
    logic          n2_en_reg, n2_en_next;
    logic [SW-1:0] n2_addr_reg, n2_addr_next;
    logic          n2_is_next_reg, n2_is_next_next;
    logic [LW-1:0] n2_val_reg, n2_val_next;
    logic          s_wr_reg, s_wr_next;
    logic [EW-1:0] s_ent_reg, s_ent_next;

    // result register
    logic          rsp_valid_reg, rsp_valid_next;
    logic [OW-1:0] head_slot_reg, head_slot_next;
    logic [OW-1:0] tail_slot_reg, tail_slot_next;
    logic          list_empty_reg, list_empty_next;
    logic [OW-1:0] tile_x_reg, tile_x_next;
    logic [OW-1:0] tile_y_reg, tile_y_next;
    logic          rejected_reg, rejected_next;

    // memory and divider hookup
    logic          mem_wr_en;
    logic [SW-1:0] mem_wr_addr;
    logic [EW-1:0] mem_wr_data;
    logic          mem_rd_en;
    logic [SW-1:0] mem_rd_addr;
    logic [EW-1:0] mem_rd_data;

    logic          div_start;
    logic          div_busy;
    logic          div_done;
    logic [SW-1:0] div_quot;
    logic [TW-1:0] div_rem;
    logic [TW-1:0] tpa_eff;

    logic          accept;
    logic          rsp_free;
    logic [LW-1:0] slot_lw;
    logic          s_in;
    logic [LW-1:0] s_prev;
    logic [LW-1:0] s_next;
    logic [EW-1:0] ent_mod;
    logic          mod_is_next;
    logic [LW-1:0] mod_val;
    logic [EW-1:0] init_ent;

    lts_link_mem #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (EW)
    ) u_link_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    lts_div #(
        .DVD_W (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (SW'(head_reg)),
        .divisor   (tpa_eff),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // handshake and entry decode
    always_comb
    begin
        accept    = req_valid && (state_reg == lts_pkg::ST_IDLE);
        rsp_free  = !rsp_valid_reg || !rsp_stall;
        slot_lw   = LW'(slot_reg);
        s_in      = mem_rd_data[IN_BIT];
        s_prev    = mem_rd_data[2*LW-1:LW];
        s_next    = mem_rd_data[LW-1:0];
        tpa_eff   = (tpa_reg == '0) ? TW'(1) : tpa_reg;
        div_start = (state_reg == lts_pkg::ST_DIV_GO);
    end

    // neighbor entry with one link field replaced
    always_comb
    begin
        mod_is_next = (state_reg == lts_pkg::ST_WR_1) ? n1_is_next_reg : n2_is_next_reg;
        mod_val     = (state_reg == lts_pkg::ST_WR_1) ? n1_val_reg : n2_val_reg;
        ent_mod     = mem_rd_data;
        if (mod_is_next)
        begin
            ent_mod[LW-1:0] = mod_val;
        end
        else
        begin
            ent_mod[2*LW-1:LW] = mod_val;
        end
    end

    // entry written by the clearing pass
    always_comb
    begin
        init_ent[IN_BIT]        = 1'b1;
        init_ent[2*LW-1:LW]     = (init_cnt_reg == '0) ? LINK_NONE
                                                       : LW'(init_cnt_reg) - LW'(1);
        init_ent[LW-1:0]        = LW'(init_cnt_reg) + LW'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lts_pkg::ST_INIT:
            begin
                if (init_cnt_reg == LAST_SLOT)
                begin
                    state_next = lts_pkg::ST_IDLE;
                end
            end
            lts_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lts_pkg::ST_RD_S;
                end
            end
            lts_pkg::ST_RD_S:
            begin
                state_next = lts_pkg::ST_CHK;
            end
            lts_pkg::ST_CHK:
            begin
                if (n1_en_next)
                begin
                    state_next = lts_pkg::ST_RD_1;
                end
                else if (n2_en_next)
                begin
                    state_next = lts_pkg::ST_RD_2;
                end
                else if (s_wr_next)
                begin
                    state_next = lts_pkg::ST_WR_S;
                end
                else
                begin
                    state_next = lts_pkg::ST_DIV_GO;
                end
            end
            lts_pkg::ST_RD_1:
            begin
                state_next = lts_pkg::ST_WR_1;
            end
            lts_pkg::ST_WR_1:
            begin
                state_next = n2_en_reg ? lts_pkg::ST_RD_2 : lts_pkg::ST_WR_S;
            end
            lts_pkg::ST_RD_2:
            begin
                state_next = lts_pkg::ST_WR_2;
            end
            lts_pkg::ST_WR_2:
            begin
                state_next = lts_pkg::ST_WR_S;
            end
            lts_pkg::ST_WR_S:
            begin
                state_next = lts_pkg::ST_DIV_GO;
            end
            lts_pkg::ST_DIV_GO:
            begin
                state_next = lts_pkg::ST_DIV_WAIT;
            end
            lts_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = lts_pkg::ST_DONE;
                end
            end
            lts_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = lts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lts_pkg::ST_INIT;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        op_next         = op_reg;
        slot_next       = slot_reg;
        bad_next        = bad_reg;
        rej_next        = rej_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        init_cnt_next   = init_cnt_reg;
        tpa_next        = cfg_wr_en ? cfg_wr_data : tpa_reg;
        n1_en_next      = n1_en_reg;
        n1_addr_next    = n1_addr_reg;
        n1_is_next_next = n1_is_next_reg;
        n1_val_next     = n1_val_reg;
        n2_en_next      = n2_en_reg;
        n2_addr_next    = n2_addr_reg;
        n2_is_next_next = n2_is_next_reg;
        n2_val_next     = n2_val_reg;
        s_wr_next       = s_wr_reg;
        s_ent_next      = s_ent_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        head_slot_next  = head_slot_reg;
        tail_slot_next  = tail_slot_reg;
        list_empty_next = list_empty_reg;
        tile_x_next     = tile_x_reg;
        tile_y_next     = tile_y_reg;
        rejected_next   = rejected_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = slot_reg;
        mem_wr_data     = s_ent_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = slot_reg;
        case (state_reg)
            lts_pkg::ST_INIT:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = init_cnt_reg;
                mem_wr_data   = init_ent;
                init_cnt_next = init_cnt_reg + SW'(1);
            end
            lts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op;
                    slot_next = SW'(slot_index);
                    bad_next  = (32'(slot_index) >= SLOT_COUNT) || (op == lts_pkg::OP_RSVD);
                end
            end
            lts_pkg::ST_RD_S:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = slot_reg;
            end
            lts_pkg::ST_CHK:
            begin
                // decide on the entry of the named slot and plan the link updates
                rej_next   = 1'b0;
                n1_en_next = 1'b0;
                n2_en_next = 1'b0;
                s_wr_next  = 1'b0;
                if (bad_reg)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    case (op_reg)
                        lts_pkg::OP_APPEND_TAIL:
                        begin
                            if (s_in)
                            begin
                                rej_next = (slot_lw != tail_reg);
                            end
                            else
                            begin
                                n1_en_next      = (tail_reg != LINK_NONE);
                                n1_addr_next    = SW'(tail_reg);
                                n1_is_next_next = 1'b1;
                                n1_val_next     = slot_lw;
                                s_wr_next       = 1'b1;
                                s_ent_next      = {1'b1, tail_reg, LINK_NONE};
                                tail_next       = slot_lw;
                                if (tail_reg == LINK_NONE)
                                begin
                                    head_next = slot_lw;
                                end
                            end
                        end
                        lts_pkg::OP_APPEND_HEAD:
                        begin
                            if (s_in)
                            begin
                                rej_next = (slot_lw != head_reg);
                            end
                            else
                            begin
                                n1_en_next      = (head_reg != LINK_NONE);
                                n1_addr_next    = SW'(head_reg);
                                n1_is_next_next = 1'b0;
                                n1_val_next     = slot_lw;
                                s_wr_next       = 1'b1;
                                s_ent_next      = {1'b1, LINK_NONE, head_reg};
                                head_next       = slot_lw;
                                if (head_reg == LINK_NONE)
                                begin
                                    tail_next = slot_lw;
                                end
                            end
                        end
                        lts_pkg::OP_UNLINK:
                        begin
                            if (s_in)
                            begin
                                // predecessor takes our next, successor takes our prev
                                n1_en_next      = (s_prev != LINK_NONE);
                                n1_addr_next    = SW'(s_prev);
                                n1_is_next_next = 1'b1;
                                n1_val_next     = s_next;
                                n2_en_next      = (s_next != LINK_NONE);
                                n2_addr_next    = SW'(s_next);
                                n2_is_next_next = 1'b0;
                                n2_val_next     = s_prev;
                                s_wr_next       = 1'b1;
                                s_ent_next      = {1'b0, LINK_NONE, LINK_NONE};
                                if (s_prev == LINK_NONE)
                                begin
                                    head_next = s_next;
                                end
                                if (s_next == LINK_NONE)
                                begin
                                    tail_next = s_prev;
                                end
                            end
                            else
                            begin
                                rej_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            rej_next = 1'b1;
                        end
                    endcase
                end
            end
            lts_pkg::ST_RD_1:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = n1_addr_reg;
            end
            lts_pkg::ST_WR_1:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = n1_addr_reg;
                mem_wr_data = ent_mod;
            end
            lts_pkg::ST_RD_2:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = n2_addr_reg;
            end
            lts_pkg::ST_WR_2:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = n2_addr_reg;
                mem_wr_data = ent_mod;
            end
            lts_pkg::ST_WR_S:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = slot_reg;
                mem_wr_data = s_ent_reg;
            end
            lts_pkg::ST_DIV_GO:
            begin
            end
            lts_pkg::ST_DIV_WAIT:
            begin
            end
            lts_pkg::ST_DONE:
            begin
                // load the result register, zero fields when the list is empty
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rejected_next   = rej_reg;
                    list_empty_next = (head_reg == LINK_NONE);
                    if (head_reg == LINK_NONE)
                    begin
                        head_slot_next = '0;
                        tail_slot_next = '0;
                        tile_x_next    = '0;
                        tile_y_next    = '0;
                    end
                    else
                    begin
                        head_slot_next = OW'(head_reg);
                        tail_slot_next = OW'(tail_reg);
                        tile_x_next    = (32'(div_rem) > 255) ? OW'(255) : OW'(div_rem);
                        tile_y_next    = (32'(div_quot) > 255) ? OW'(255) : OW'(div_quot);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lts_pkg::ST_INIT;
            head_reg      <= '0;
            tail_reg      <= LW'(SLOT_COUNT - 1);
            init_cnt_reg  <= '0;
            tpa_reg       <= lts_pkg::TPA_RESET;
            rsp_valid_reg <= 1'b0;
            n1_en_reg     <= 1'b0;
            n2_en_reg     <= 1'b0;
            s_wr_reg      <= 1'b0;
            rej_reg       <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            init_cnt_reg  <= init_cnt_next;
            tpa_reg       <= tpa_next;
            rsp_valid_reg <= rsp_valid_next;
            n1_en_reg     <= n1_en_next;
            n2_en_reg     <= n2_en_next;
            s_wr_reg      <= s_wr_next;
            rej_reg       <= rej_next;
            bad_reg       <= bad_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        slot_reg       <= slot_next;
        n1_addr_reg    <= n1_addr_next;
        n1_is_next_reg <= n1_is_next_next;
        n1_val_reg     <= n1_val_next;
        n2_addr_reg    <= n2_addr_next;
        n2_is_next_reg <= n2_is_next_next;
        n2_val_reg     <= n2_val_next;
        s_ent_reg      <= s_ent_next;
        head_slot_reg  <= head_slot_next;
        tail_slot_reg  <= tail_slot_next;
        list_empty_reg <= list_empty_next;
        tile_x_reg     <= tile_x_next;
        tile_y_reg     <= tile_y_next;
        rejected_reg   <= rejected_next;
    end

    assign req_stall   = (state_reg != lts_pkg::ST_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign head_slot   = head_slot_reg;
    assign tail_slot   = tail_slot_reg;
    assign list_empty  = list_empty_reg;
    assign head_tile_x = tile_x_reg;
    assign head_tile_y = tile_y_reg;
    assign rejected    = rejected_reg;

    // head and tail are absent together
    `LTS_ASSERT_IMP(a_ends_agree, clk, rst_n, 1'b1, ((head_reg == LINK_NONE) == (tail_reg == LINK_NONE)))
    // no link memory write while waiting for an item or for the result slot
    `LTS_ASSERT_IMP(a_no_idle_write, clk, rst_n, (state_reg == lts_pkg::ST_IDLE || state_reg == lts_pkg::ST_DONE), !mem_wr_en)
    // an ignored request never reaches a write step
    `LTS_ASSERT_IMP(a_rej_no_write, clk, rst_n, (state_reg == lts_pkg::ST_WR_1 || state_reg == lts_pkg::ST_WR_2 || state_reg == lts_pkg::ST_WR_S), !rej_reg)
    // the divider is only started when it is free
    `LTS_ASSERT_IMP(a_div_free, clk, rst_n, div_start, !div_busy)
    // a result only appears out of the done step
    `LTS_ASSERT_IMP(a_rsp_from_done, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg == lts_pkg::ST_DONE))

endmodule

`default_nettype wire

[rtl/core/lts_link_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module lts_link_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 19
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/lts_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module lts_div #(
    parameter int DVD_W = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DVD_W-1:0]         dividend,
    input  wire logic [lts_pkg::TPA_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic      [DVD_W-1:0]         quotient,
    output logic      [lts_pkg::TPA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int TW    = lts_pkg::TPA_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [TW-1:0]    rem_reg, rem_next;
    logic [TW-1:0]    dvs_reg, dvs_next;

    logic [TW:0]      rem_sh;
    logic [TW:0]      rem_sub;
    logic             ge;

    // one restoring step per cycle, quotient bits shift into the dividend register
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = (dvd_reg << 1) | DVD_W'(ge);
            rem_next = ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
